/* rtl/lcpf_pkg.sv */
// ----------------------------------------------------------------------------
// lcpf_pkg: shared types and constants
// Event codes, receive modes and small character helpers for the line framer.
// ----------------------------------------------------------------------------
package lcpf_pkg;

  typedef enum logic [3:0] {
    EV_DATA          = 4'd0,
    EV_ACK           = 4'd1,
    EV_EMPTY         = 4'd2,
    EV_LOCKED        = 4'd3,
    EV_BADLEN        = 4'd4,
    EV_HDRLONG       = 4'd5,
    EV_PONG_LOCKED   = 4'd6,
    EV_PONG_UNLOCKED = 4'd7,
    EV_ADDR_NONE     = 4'd8,
    EV_ADDR_LOCKED   = 4'd9,
    EV_ADDR_OK       = 4'd10
  } event_t;

  typedef enum logic [1:0] {
    MODE_LINE    = 2'd0,
    MODE_PAYLOAD = 2'd1,
    MODE_DISCARD = 2'd2
  } mode_t;

  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChBrace = 8'h7b;

  // "UNSIGNED " character by position
  function automatic logic [7:0] cmd_unsigned(input logic [3:0] i);
    case (i)
      4'd0: cmd_unsigned = "U";
      4'd1: cmd_unsigned = "N";
      4'd2: cmd_unsigned = "S";
      4'd3: cmd_unsigned = "I";
      4'd4: cmd_unsigned = "G";
      4'd5: cmd_unsigned = "N";
      4'd6: cmd_unsigned = "E";
      4'd7: cmd_unsigned = "D";
      default: cmd_unsigned = " ";
    endcase
  endfunction

  function automatic logic [7:0] cmd_ping(input logic [3:0] i);
    case (i)
      4'd0: cmd_ping = "P";
      4'd1: cmd_ping = "I";
      4'd2: cmd_ping = "N";
      default: cmd_ping = "G";
    endcase
  endfunction

  function automatic logic [7:0] cmd_address(input logic [3:0] i);
    case (i)
      4'd0: cmd_address = "A";
      4'd1: cmd_address = "D";
      4'd2: cmd_address = "D";
      4'd3: cmd_address = "R";
      4'd4: cmd_address = "E";
      4'd5: cmd_address = "S";
      default: cmd_address = "S";
    endcase
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    is_ws = (c == 8'h20) || (c == 8'h09) || (c == 8'h0b) || (c == 8'h0c);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= 8'h30) && (c <= 8'h39);
  endfunction

endpackage

/* rtl/line_command_payload_framer.sv */
// ----------------------------------------------------------------------------
// line_command_payload_framer: serial command line and payload framer
// Gathers CR/LF lines, decodes PING, ADDRESS and UNSIGNED, forwards payload.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                              | tuser / tlast
//  s_axis   | in  | [7:0] rx_byte                      | tuser[0] wallet_present,
//           |     |                                    | tuser[1] wallet_open
//  m_axis   | out | [3:0] event_code, [11:4] data_byte | tlast = last
//
// A stored or discarded byte is taken in S_IDLE; a payload byte then passes
// S_DATA. A line end walks the line store through the RAM read port twice,
// one byte per cycle: once for its length, once to parse it (up to LINE_CAP-1
// bytes each); an inline body then passes each byte through S_WAIT and S_BODY.
// s_axis_tready is low during that walk and while a result waits on m_axis.
// Reset returns to line mode, line empty.
module line_command_payload_framer
  import lcpf_pkg::*;
#(
  parameter int MAX_PAYLOAD = 4096,
  parameter int LINE_CAP    = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser,   // [0] wallet_present, [1] wallet_open
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [3:0] event_code, [11:4] data_byte
  output logic        m_axis_tlast
);

  localparam int AW = $clog2(LINE_CAP);
  localparam int CW = $clog2(LINE_CAP + 1);
  localparam int VW = $clog2(MAX_PAYLOAD + 2);
  localparam logic [CW-1:0] CapLim = CW'(LINE_CAP - 1);
  localparam logic [VW-1:0] MaxVal = VW'(MAX_PAYLOAD);
  localparam logic [6:0] ResLim = 7'd64;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_LEN   = 8'b00000010,  // find line length
    S_PARSE = 8'b00000100,  // header, spaces, digits
    S_BODY  = 8'b00001000,  // stream inline body
    S_EMIT  = 8'b00010000,  // emit single pending result
    S_WAIT  = 8'b00100000,  // read latency bubble
    S_DATA  = 8'b01000000,  // emit payload byte then maybe verdict
    S_OUT   = 8'b10000000   // wait for output to drain
  } state_t;

  // parse sub phases
  typedef enum logic [4:0] {
    P_HDR = 5'b00001,
    P_SP1 = 5'b00010,
    P_WS  = 5'b00100,
    P_DIG = 5'b01000,
    P_SP2 = 5'b10000
  } phase_t;

  state_t state;
  phase_t phase;
  mode_t  rx_mode;

  logic [CW-1:0] line_count;
  logic [CW-1:0] len;
  logic [CW-1:0] idx;      // address issued
  logic [CW-1:0] p_pos;
  logic [VW-1:0] val;
  logic          dig_seen;
  logic [VW-1:0] expected_count;
  logic [VW-1:0] received_count;
  logic          first_byte_zero;
  logic          hdr_ok_u, hdr_ok_p, hdr_ok_a;
  logic          present, open;
  logic [7:0]    cur;
  logic [6:0]    nres;
  event_t        pend_code;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    rdata;
  logic          rd_valid;   // rdata corresponds to idx-1

  lcpf_ram #(.Width(8), .Depth(LINE_CAP)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (s_axis_tdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  logic acc_in, out_free;
  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;
  assign acc_in   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  logic eol;
  assign eol = (s_axis_tdata == ChLf) || (s_axis_tdata == ChCr);

  logic [CW-1:0] rpos;  // position of rdata
  assign rpos = idx - CW'(1);

  assign ram_we    = acc_in && (rx_mode != MODE_PAYLOAD) && (rx_mode != MODE_DISCARD)
                     && !eol && (line_count < CapLim);
  assign ram_waddr = line_count[AW-1:0];
  // body bytes hold their address so rdata stays put while the output stalls
  assign ram_raddr = (state == S_BODY) ? rpos[AW-1:0] : idx[AW-1:0];

  // output register load helper signals
  logic       o_load;
  event_t     o_code;
  logic [7:0] o_byte;
  logic       o_last;

  logic [VW+3:0] val_mul;
  assign val_mul = {val, 3'b000} + {3'b000, val, 1'b0}
                   + (VW+4)'(rdata - 8'h30);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rx_mode <= MODE_LINE;
      line_count <= '0;
      expected_count <= '0;
      received_count <= '0;
      first_byte_zero <= 1'b0;
      m_axis_tvalid <= 1'b0;
      rd_valid <= 1'b0;
      idx <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (o_load) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= {4'd0, o_byte, o_code};
        m_axis_tlast  <= o_last;
      end
      rd_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (acc_in) begin
            present <= s_axis_tuser[0];
            open    <= s_axis_tuser[1];
            cur     <= s_axis_tdata;
            if (rx_mode == MODE_PAYLOAD) begin
              if (received_count == '0) first_byte_zero <= (s_axis_tdata == 8'd0);
              received_count <= received_count + VW'(1);
              state <= S_DATA;
            end else if (rx_mode == MODE_DISCARD) begin
              if (eol) rx_mode <= MODE_LINE;
            end else begin
              rx_mode <= MODE_LINE;
              if (eol) begin
                if (line_count != '0) begin
                  len <= '0; idx <= '0; state <= S_WAIT;
                  phase <= P_HDR;
                end
              end else if (line_count < CapLim) begin
                line_count <= line_count + CW'(1);
              end else begin
                line_count <= '0;
                rx_mode <= MODE_DISCARD;
                pend_code <= EV_HDRLONG;
                state <= S_EMIT;
              end
            end
          end
        end
        S_DATA: begin
          if (out_free) begin
            if (received_count >= expected_count) begin
              pend_code <= first_byte_zero ? EV_EMPTY : (open ? EV_ACK : EV_LOCKED);
              rx_mode <= MODE_LINE;
              expected_count <= '0;
              received_count <= '0;
              state <= S_EMIT;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_EMIT: begin
          if (out_free) state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) state <= S_IDLE;
        end
        S_WAIT: begin
          // issue read of idx, then go to scanning
          idx <= idx + CW'(1);
          rd_valid <= 1'b1;
          state <= (phase == P_HDR && len == '0 && idx == '0) ? S_LEN : S_BODY;
        end
        S_LEN: begin
          // rdata holds line_store[rpos]
          if (rpos >= line_count || rdata == 8'd0) begin
            len <= rpos;
            idx <= '0;
            hdr_ok_u <= 1'b1; hdr_ok_p <= 1'b1; hdr_ok_a <= 1'b1;
            val <= '0; dig_seen <= 1'b0;
            state <= S_PARSE;
            line_count <= '0;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_PARSE: begin
          // first cycle after S_LEN re-issues read at idx
          if (!rd_valid) begin
            idx <= idx + CW'(1);
            rd_valid <= 1'b1;
          end else begin
            idx <= idx + CW'(1);
            rd_valid <= 1'b1;
            case (phase)
              P_HDR: begin
                if (rpos < len) begin
                  if (rdata != cmd_unsigned(rpos[3:0]) || rpos > CW'(8)) hdr_ok_u <= 1'b0;
                  if (rpos > CW'(3) || rdata != cmd_ping(rpos[3:0])) hdr_ok_p <= 1'b0;
                  if (rpos > CW'(6) || rdata != cmd_address(rpos[3:0])) hdr_ok_a <= 1'b0;
                end
                if (rpos == CW'(8) || rpos + CW'(1) >= len) begin
                  if (len >= CW'(9) && hdr_ok_u && rpos == CW'(8)
                      && rdata == cmd_unsigned(4'd8)) begin
                    phase <= P_SP1;
                  end else begin
                    rd_valid <= 1'b0;
                    state <= S_EMIT;
                    if (len == CW'(4) && hdr_ok_p && rpos == CW'(3)
                        && rdata == cmd_ping(4'd3))
                      pend_code <= open ? EV_PONG_UNLOCKED : EV_PONG_LOCKED;
                    else if (len == CW'(7) && hdr_ok_a && rpos == CW'(6)
                             && rdata == cmd_address(4'd6))
                      pend_code <= !present ? EV_ADDR_NONE
                                   : (open ? EV_ADDR_OK : EV_ADDR_LOCKED);
                    else state <= S_IDLE;
                  end
                end
              end
              P_SP1: begin
                if (rpos >= len) begin
                  rd_valid <= 1'b0; pend_code <= EV_EMPTY; state <= S_EMIT;
                end else if (rdata == ChSpace) begin
                end else if (rdata == ChBrace) begin
                  rd_valid <= 1'b0; idx <= rpos; p_pos <= rpos;
                  nres <= '0; state <= S_WAIT;
                end else begin
                  p_pos <= rpos;
                  phase <= is_ws(rdata) ? P_WS : (is_digit(rdata) ? P_DIG : P_SP2);
                  if (is_digit(rdata)) begin
                    val <= VW'(rdata - 8'h30); dig_seen <= 1'b1;
                  end
                  if (!is_ws(rdata) && !is_digit(rdata)) begin
                    rd_valid <= 1'b0; idx <= rpos;
                  end
                end
              end
              P_WS: begin
                if (rpos < len && is_ws(rdata)) begin
                end else if (rpos < len && is_digit(rdata)) begin
                  val <= VW'(rdata - 8'h30); dig_seen <= 1'b1; phase <= P_DIG;
                end else begin
                  // no digits: rewind to p
                  rd_valid <= 1'b0; idx <= p_pos; phase <= P_SP2;
                end
              end
              P_DIG: begin
                if (rpos < len && is_digit(rdata)) begin
                  if (val_mul > (VW+4)'(MaxVal)) val <= MaxVal + VW'(1);
                  else val <= val_mul[VW-1:0];
                end else begin
                  rd_valid <= 1'b0; idx <= rpos; phase <= P_SP2;
                end
              end
              P_SP2: begin
                if (rpos < len && rdata == ChSpace) begin
                end else if (rpos < len && rdata == ChBrace) begin
                  rd_valid <= 1'b0; idx <= rpos;
                  nres <= '0; state <= S_WAIT;
                end else begin
                  rd_valid <= 1'b0;
                  if (!dig_seen || val == '0 || val > MaxVal) begin
                    pend_code <= EV_BADLEN; state <= S_EMIT;
                  end else begin
                    expected_count <= val;
                    received_count <= '0;
                    first_byte_zero <= 1'b0;
                    rx_mode <= MODE_PAYLOAD;
                    state <= S_IDLE;
                  end
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_BODY: begin
          // rdata holds byte at rpos; hold until output frees
          if (out_free) begin
            if (rpos < len && nres < ResLim - 7'd1) begin
              nres <= nres + 7'd1;
              rd_valid <= 1'b1;
              state <= S_WAIT;
            end else begin
              pend_code <= open ? EV_ACK : EV_LOCKED;
              state <= S_EMIT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register loads
  always_comb begin
    o_load = 1'b0;
    o_code = EV_DATA;
    o_byte = 8'd0;
    o_last = 1'b1;
    case (state)
      S_DATA: begin
        o_load = out_free;
        o_byte = cur;
        o_last = received_count < expected_count;
      end
      S_EMIT: begin
        o_load = out_free;
        o_code = pend_code;
      end
      S_BODY: begin
        o_load = out_free && rpos < len && nres < ResLim - 7'd1;
        o_byte = rdata;
        o_last = 1'b0;
      end
      default: o_load = 1'b0;
    endcase
  end

endmodule

/* rtl/lcpf_ram.sv */
// ----------------------------------------------------------------------------
// lcpf_ram: generic simple dual-port RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module lcpf_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* tb/sv/line_command_payload_framer_tb.sv */
// ----------------------------------------------------------------------------
// line_command_payload_framer_tb: self-checking bench for the command framer
// Sends directed and random command lines and counted payloads as bytes and
// checks every result item against a behavioral model of the framer.
// ----------------------------------------------------------------------------
module line_command_payload_framer_tb;
  import lcpf_pkg::*;

  localparam int MaxPayload = 4096;
  localparam int LineCap    = 64;
  localparam int ResultCap  = 64;
  localparam int WatchLimit = 20000;

  typedef struct packed {
    logic [3:0] code;
    logic [7:0] data;
    logic       last;
  } framer_event_t;

  // behavioral model of the framer plus the queue of pending results
  class framer_scoreboard;
    mode_t           mode;
    logic [7:0]      line_buf [LineCap];
    int              line_len;
    int              pay_total;
    int              pay_seen;
    bit              pay_zero;
    framer_event_t   pending [$];
    framer_event_t   burst [$];
    int              n_fail;
    int              n_checked;

    function void reset_state();
      mode = MODE_LINE;
      line_len = 0;
      pay_total = 0;
      pay_seen = 0;
      pay_zero = 0;
      pending.delete();
      n_fail = 0;
      n_checked = 0;
    endfunction

    function void emit(event_t code, logic [7:0] data);
      framer_event_t ev;
      if (burst.size() >= ResultCap) return;
      ev.code = code;
      ev.data = data;
      ev.last = 1'b0;
      burst.push_back(ev);
    endfunction

    function bit blank(logic [7:0] c);
      return c == " " || c == 8'h09 || c == 8'h0b || c == 8'h0c;
    endfunction

    // inline json body: data items then the verdict, capped at the limit
    function void send_body(int from, int len, bit open);
      for (int i = from; i < len && i < LineCap && burst.size() < ResultCap - 1; i++)
        emit(EV_DATA, line_buf[i]);
      emit(open ? EV_ACK : EV_LOCKED, 8'h00);
    endfunction

    function void parse_line(bit present, bit open);
      int len;
      int p;
      int q;
      int stop;
      int val;
      string pre;
      len = 0;
      while (len < line_len && line_buf[len] != 8'h00) len++;
      pre = "";
      for (int i = 0; i < len && i < 9; i++) pre = {pre, string'(line_buf[i])};
      if (len >= 9 && pre == "UNSIGNED ") begin
        p = 9;
        while (p < len && line_buf[p] == " ") p++;
        if (p >= len) begin
          emit(EV_EMPTY, 8'h00);
          return;
        end
        if (line_buf[p] == "{") begin
          send_body(p, len, open);
          return;
        end
        q = p;
        while (q < len && blank(line_buf[q])) q++;
        val = 0;
        stop = p;
        if (q < len && line_buf[q] >= "0" && line_buf[q] <= "9") begin
          while (q < len && line_buf[q] >= "0" && line_buf[q] <= "9") begin
            val = val * 10 + (line_buf[q] - "0");
            if (val > MaxPayload) val = MaxPayload + 1;
            q++;
          end
          stop = q;
        end
        while (stop < len && line_buf[stop] == " ") stop++;
        if (stop < len && line_buf[stop] == "{") begin
          send_body(stop, len, open);
          return;
        end
        if (val == 0 || val > MaxPayload) begin
          emit(EV_BADLEN, 8'h00);
          return;
        end
        pay_total = val;
        pay_seen = 0;
        pay_zero = 0;
        mode = MODE_PAYLOAD;
        return;
      end
      if (len == 4 && pre == "PING") begin
        emit(open ? EV_PONG_UNLOCKED : EV_PONG_LOCKED, 8'h00);
        return;
      end
      if (len == 7 && pre == "ADDRESS") begin
        if (!present) emit(EV_ADDR_NONE, 8'h00);
        else emit(open ? EV_ADDR_OK : EV_ADDR_LOCKED, 8'h00);
      end
    endfunction

    // note one accepted byte and queue what it should cause
    function void note_byte(logic [7:0] c, bit present, bit open);
      bit eol;
      eol = (c == ChLf) || (c == ChCr);
      burst.delete();
      if (mode == MODE_PAYLOAD) begin
        if (pay_seen == 0) pay_zero = (c == 8'h00);
        emit(EV_DATA, c);
        pay_seen++;
        if (pay_seen >= pay_total) begin
          emit(pay_zero ? EV_EMPTY : (open ? EV_ACK : EV_LOCKED), 8'h00);
          mode = MODE_LINE;
          pay_total = 0;
          pay_seen = 0;
        end
      end else if (mode == MODE_DISCARD) begin
        if (eol) mode = MODE_LINE;
      end else begin
        if (eol) begin
          if (line_len != 0) begin
            parse_line(present, open);
            line_len = 0;
          end
        end else if (line_len < LineCap - 1) begin
          line_buf[line_len] = c;
          line_len++;
        end else begin
          line_len = 0;
          mode = MODE_DISCARD;
          emit(EV_HDRLONG, 8'h00);
        end
      end
      if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) pending.push_back(burst[i]);
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(logic [15:0] tdata, logic tlast);
      framer_event_t want;
      n_checked++;
      if (pending.size() == 0) begin
        $error("unexpected result item: code %0d data %0h", tdata[3:0], tdata[11:4]);
        n_fail++;
        return;
      end
      want = pending.pop_front();
      if (tdata[3:0] !== want.code) begin
        $error("event_code: expected %0d, got %0d", want.code, tdata[3:0]);
        n_fail++;
      end
      if (tdata[11:4] !== want.data) begin
        $error("data_byte: expected %0h, got %0h", want.data, tdata[11:4]);
        n_fail++;
      end
      if (tdata[15:12] !== 4'h0) begin
        $error("tdata pad: expected 0, got %0h", tdata[15:12]);
        n_fail++;
      end
      if (tlast !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, tlast);
        n_fail++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  framer_scoreboard sb;
  int  idle_cycles;
  int  bytes_sent;
  int  burst_left;
  int  stall_mode;

  line_command_payload_framer #(
    .MAX_PAYLOAD(MaxPayload),
    .LINE_CAP(LineCap)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // receiver: stall pattern switches between none, light and heavy
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_mode <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // send one byte, idling first when the current burst is used up
  task automatic send_byte(input logic [7:0] c, input bit present, input bit open);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= {open, present};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_byte(c, present, open);
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input bit present, input bit open);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], present, open);
  endtask

  task automatic send_payload(input int n, input bit zero_first, input bit open);
    for (int i = 0; i < n; i++)
      send_byte((i == 0 && zero_first) ? 8'h00 : 8'($urandom), 1'b1, open);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic string rand_body(int n);
    string s;
    s = "{";
    for (int i = 1; i < n; i++) s = {s, string'(8'($urandom_range(32, 126)))};
    return s;
  endfunction

  function automatic logic [7:0] eol_char();
    return $urandom_range(0, 1) ? ChCr : ChLf;
  endfunction

  initial begin
    int    kind;
    int    n;
    bit    pr;
    bit    op;
    string body;
    sb = new();
    sb.reset_state();
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'h00;
    s_axis_tuser = 2'b00;
    bytes_sent = 0;
    burst_left = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: each command, special case and field extreme
    send_text("PING\r", 1, 0);
    send_text("PING\n", 1, 1);
    send_byte(ChCr, 0, 0);
    send_text("ADDRESS\n", 0, 1);
    send_text("ADDRESS\r", 1, 0);
    send_text("ADDRESS\n", 1, 1);
    send_text("UNSIGNED   \n", 1, 1);
    send_text("UNSIGNED +5\n", 1, 1);
    send_text("UNSIGNED 0\r", 1, 1);
    send_text("UNSIGNED 99999\n", 1, 1);
    send_text("UNSIGNED {\"a\":1}\n", 1, 0);
    send_text("UNSIGNED 12 {x}\r", 1, 1);
    send_text("PI", 1, 1);
    send_byte(8'h00, 1, 1);
    send_text("NG\n", 1, 1);
    send_text("HELLO\n", 0, 0);
    send_text("UNSIGNED \t3xy\n", 1, 1);
    send_payload(3, 1, 1);
    send_text("UNSIGNED 2\n", 1, 0);
    send_byte(8'hff, 1, 0);
    send_byte(ChLf, 1, 0);
    send_text("UNSIGNED 1\n", 1, 1);
    send_byte(8'h7f, 1, 1);
    send_text("UNSIGNED 4097\n", 1, 1);
    send_text("UNSIGNED 0040\n", 1, 1);
    send_payload(40, 0, 1);
    send_text({"UNSIGNED ", rand_body(54), "\n"}, 1, 1);
    for (int i = 0; i < 70; i++) send_byte("A", 1, 1);
    send_text("\nPING\n", 1, 1);
    drain();

    // random: mostly well-formed commands, some noise and broken lines
    while (bytes_sent < 460) begin
      kind = $urandom_range(0, 19);
      pr = $urandom_range(0, 1);
      op = $urandom_range(0, 1);
      case (kind)
        0, 1: send_text("PING", pr, op);
        2, 3: send_text("ADDRESS", pr, op);
        4, 5, 6, 7: begin
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5000) : $urandom_range(1, 8);
          if (n > 40 && n <= MaxPayload) n = $urandom_range(1, 8);
          send_text($sformatf("UNSIGNED %0d", n), pr, op);
          send_byte(eol_char(), pr, op);
          if (n >= 1 && n <= MaxPayload)
            send_payload(n, $urandom_range(0, 3) == 0, $urandom_range(0, 1));
          continue;
        end
        8, 9, 10: begin
          body = rand_body($urandom_range(1, 54));
          send_text({"UNSIGNED ", body}, pr, op);
        end
        11: send_text("UNSIGNED ", pr, op);
        12: send_text({"UNSIGNED ", $urandom_range(0, 1) ? "-" : "+", "7"}, pr, op);
        13: begin
          n = $urandom_range(1, 80);
          for (int i = 0; i < n; i++) send_byte(8'($urandom), pr, op);
        end
        14: begin
          n = $urandom_range(60, 70);
          for (int i = 0; i < n; i++) send_byte("Z", pr, op);
        end
        15: send_text("PIN", pr, op);
        16: begin
          send_text("PING", pr, op);
          send_byte(8'h00, pr, op);
          send_text("junk", pr, op);
        end
        default: ;
      endcase
      send_byte(eol_char(), pr, op);
      if ($urandom_range(0, 59) == 0) drain();
    end
    drain();

    $display("covered %0d bytes in, %0d result items checked", bytes_sent, sb.n_checked);
    $display("commands, inline bodies, counted payloads, long lines and noise exercised");
    if (sb.n_fail == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/lcpf_pkg.sv
rtl/lcpf_ram.sv
rtl/line_command_payload_framer.sv
tb/sv/line_command_payload_framer_tb.sv
